### hw/rtl/sips_pkg.sv
// shared types, constants and lookup tables of the icon pixel shader
// no dependencies; imported by the interfaces and all shader modules
package sips_pkg;

    // icon geometry
    localparam int ICON_SIDE  = 18;
    localparam int SUBSAMPLES = 4;
    localparam int NSAMP      = SUBSAMPLES * SUBSAMPLES;
    localparam int GRID_D     = 2 * ICON_SIDE * SUBSAMPLES;

    // field widths
    localparam int PIX_W = 5;
    localparam int CH_W  = 8;

    // sample position u in units of 1/GRID_D, and |2u - GRID_D|
    localparam int U_W    = $clog2(2 * SUBSAMPLES * (2 ** PIX_W));
    localparam int A_W    = U_W + 1;
    localparam int SQ_W   = 2 * A_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int AR10_W = A_W + 4;
    localparam int U15_W  = U_W + 4;
    localparam int TRI_W  = A_W + 5;
    localparam int HIT_W  = $clog2(NSAMP + 1);
    localparam int ROW_W  = $clog2(SUBSAMPLES + 1);

    // circle: 10000 * (c^2 + r^2) <= 3136 * D^2
    localparam longint CIRC_LIM = (longint'(3136) * GRID_D * GRID_D) / 10000;
    // triangle: 10|r| + 15u <= 12 D
    localparam int TRI_LIM = 12 * GRID_D;

    // percent bounds turned into sample positions (ceil for lower, floor for upper)
    localparam int SQ_LO   = (24 * GRID_D + 99) / 100;
    localparam int SQ_HI   = (76 * GRID_D) / 100;
    localparam int BAR1_LO = (26 * GRID_D + 99) / 100;
    localparam int BAR1_HI = (43 * GRID_D) / 100;
    localparam int BAR2_LO = (57 * GRID_D + 99) / 100;
    localparam int BAR2_HI = (74 * GRID_D) / 100;

    // configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 2'd3;

    localparam logic [CH_W-1:0] RED_RST   = 8'd220;
    localparam logic [CH_W-1:0] GREEN_RST = 8'd60;
    localparam logic [CH_W-1:0] BLUE_RST  = 8'd60;

    // figure codes
    typedef enum logic [1:0] {
        SHAPE_CIRCLE   = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_TRIANGLE = 2'd2,
        SHAPE_PAUSE    = 2'd3
    } t_shape;

    // per-column terms of the sample grid
    typedef struct packed {
        logic [SQ_W-1:0]  sq;
        logic [U15_W-1:0] u15;
        logic             tri_lo;
        logic             in_sq;
        logic             in_bar;
    } t_xcol;

    // per-row terms of the sample grid
    typedef struct packed {
        logic [SQ_W-1:0]   sq;
        logic [AR10_W-1:0] ar10;
        logic              in_sq;
    } t_yrow;

    typedef struct packed {
        logic                         valid;
        t_xcol [SUBSAMPLES-1:0]       col;
        t_yrow [SUBSAMPLES-1:0]       row;
    } t_axis_req;

    typedef struct packed {
        logic             valid;
        logic [NSAMP-1:0] hit;
    } t_mask_req;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_color;

    // alpha = floor(255 * hits / NSAMP)
    typedef logic [CH_W-1:0] t_alpha_lut [0:NSAMP];

    function automatic t_alpha_lut make_alpha_lut();
        t_alpha_lut lut;
        for (int h = 0; h <= NSAMP; h++) begin
            lut[h] = CH_W'((255 * h) / NSAMP);
        end
        return lut;
    endfunction

    localparam t_alpha_lut ALPHA_LUT = make_alpha_lut();

endpackage

### hw/rtl/sips_pix_if.sv
// pixel coordinate request channel (valid/ready)
// depends on sips_pkg for the coordinate width
interface sips_pix_if import sips_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

### hw/rtl/sips_rgba_if.sv
// rgba result request channel (valid/ready)
// depends on sips_pkg for the channel width
interface sips_rgba_if import sips_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, output ready);
endinterface

### hw/rtl/sips_axis.sv
// stage 1: per-column and per-row terms of the sub-sample grid
// depends on sips_pkg and sips_pix_if
module sips_axis import sips_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sips_pix_if.sink        i_pix,
    input  logic            i_ready,
    output t_axis_req       o_axis
);

    logic                   r_valid;
    t_xcol [SUBSAMPLES-1:0] r_col;
    t_yrow [SUBSAMPLES-1:0] r_row;
    t_xcol [SUBSAMPLES-1:0] n_col;
    t_yrow [SUBSAMPLES-1:0] n_row;
    logic                   adv;

    // sample position 2*S*pix + 2k + 1
    function automatic logic [U_W-1:0] axis_pos(input logic [PIX_W-1:0] pix, input int k);
        return U_W'(int'(pix) * (2 * SUBSAMPLES) + 2 * k + 1);
    endfunction

    // distance from center, |2u - D|
    function automatic logic [A_W-1:0] axis_mag(input logic [U_W-1:0] pos);
        int twice;
        twice = 2 * int'(pos);
        return (twice >= GRID_D) ? A_W'(twice - GRID_D) : A_W'(GRID_D - twice);
    endfunction

    function automatic logic in_range(input logic [U_W-1:0] pos, input int lo, input int hi);
        return (32'(pos) >= 32'(lo)) && (32'(pos) <= 32'(hi));
    endfunction

    // stage moves when empty or when downstream takes its item
    assign adv         = !r_valid || i_ready;
    assign i_pix.ready = adv;

    // column and row terms
    always_comb begin
        for (int k = 0; k < SUBSAMPLES; k++) begin
            logic [U_W-1:0] pu;
            logic [U_W-1:0] pv;
            logic [A_W-1:0] mc;
            logic [A_W-1:0] mr;
            pu = axis_pos(i_pix.pixel_x, k);
            pv = axis_pos(i_pix.pixel_y, k);
            mc = axis_mag(pu);
            mr = axis_mag(pv);

            n_col[k].sq     = SQ_W'(mc) * SQ_W'(mc);
            n_col[k].u15    = U15_W'(pu) * U15_W'(15);
            n_col[k].tri_lo = (32'(pu) >= 32'(SQ_LO));
            n_col[k].in_sq  = in_range(pu, SQ_LO, SQ_HI);
            n_col[k].in_bar = in_range(pu, BAR1_LO, BAR1_HI) || in_range(pu, BAR2_LO, BAR2_HI);

            n_row[k].sq     = SQ_W'(mr) * SQ_W'(mr);
            n_row[k].ar10   = AR10_W'(mr) * AR10_W'(10);
            n_row[k].in_sq  = in_range(pv, SQ_LO, SQ_HI);
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_pix.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv && i_pix.valid) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_axis.valid = r_valid;
    assign o_axis.col   = r_col;
    assign o_axis.row   = r_row;

endmodule

### hw/rtl/sips_cover.sv
// stage 2: per-sample coverage test against the selected figure
// depends on sips_pkg
module sips_cover import sips_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_axis_req i_axis,
    input  t_shape    i_shape,
    input  logic      i_ready,
    output logic      o_ready,
    output t_mask_req o_mask
);

    logic             r_valid;
    logic [NSAMP-1:0] r_hit;
    logic [NSAMP-1:0] n_hit;
    logic             adv;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;

    // one hit bit per sub-sample, row-major
    always_comb begin
        for (int sy = 0; sy < SUBSAMPLES; sy++) begin
            for (int sx = 0; sx < SUBSAMPLES; sx++) begin
                logic [SUM_W-1:0] rad;
                logic [TRI_W-1:0] slope;
                logic             hit;
                rad   = SUM_W'(i_axis.col[sx].sq) + SUM_W'(i_axis.row[sy].sq);
                slope = TRI_W'(i_axis.col[sx].u15) + TRI_W'(i_axis.row[sy].ar10);
                case (i_shape)
                    SHAPE_CIRCLE:   hit = (rad <= SUM_W'(CIRC_LIM));
                    SHAPE_SQUARE:   hit = i_axis.col[sx].in_sq && i_axis.row[sy].in_sq;
                    SHAPE_TRIANGLE: hit = i_axis.col[sx].tri_lo && (slope <= TRI_W'(TRI_LIM));
                    SHAPE_PAUSE:    hit = i_axis.col[sx].in_bar && i_axis.row[sy].in_sq;
                    default:        hit = 1'b0;
                endcase
                n_hit[sy * SUBSAMPLES + sx] = hit;
            end
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_axis.valid;
        end
    end

    // hit mask
    always_ff @(posedge i_clk) begin
        if (adv && i_axis.valid) begin
            r_hit <= n_hit;
        end
    end

    assign o_mask.valid = r_valid;
    assign o_mask.hit   = r_hit;

endmodule

### hw/rtl/sips_alpha.sv
// stages 3 and 4: hit count, then alpha lookup into the output register
// depends on sips_pkg and sips_rgba_if
module sips_alpha import sips_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mask_req   i_mask,
    input  t_color      i_color,
    output logic        o_ready,
    sips_rgba_if.source o_rgba
);

    logic             r_cnt_valid;
    logic [HIT_W-1:0] r_cnt;
    logic [HIT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic [CH_W-1:0]  r_alpha;
    logic             adv3;
    logic             adv4;

    assign adv4    = !r_out_valid || o_rgba.ready;
    assign adv3    = !r_cnt_valid || adv4;
    assign o_ready = adv3;

    // popcount: row sums first, then the sum of rows
    always_comb begin
        logic [ROW_W-1:0] row_sum [SUBSAMPLES];
        for (int sy = 0; sy < SUBSAMPLES; sy++) begin
            row_sum[sy] = '0;
            for (int sx = 0; sx < SUBSAMPLES; sx++) begin
                row_sum[sy] = row_sum[sy] + ROW_W'(i_mask.hit[sy * SUBSAMPLES + sx]);
            end
        end
        n_cnt = '0;
        for (int sy = 0; sy < SUBSAMPLES; sy++) begin
            n_cnt = n_cnt + HIT_W'(row_sum[sy]);
        end
    end

    // count stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_valid <= 1'b0;
        end else if (adv3) begin
            r_cnt_valid <= i_mask.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && i_mask.valid) begin
            r_cnt <= n_cnt;
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv4) begin
            r_out_valid <= r_cnt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4 && r_cnt_valid) begin
            r_alpha <= ALPHA_LUT[r_cnt];
        end
    end

    // colour regs must change only while idle, unenforced; drive result directly
    assign o_rgba.valid     = r_out_valid;
    assign o_rgba.out_red   = i_color.red;
    assign o_rgba.out_green = i_color.green;
    assign o_rgba.out_blue  = i_color.blue;
    assign o_rgba.out_alpha = r_alpha;

    // count never exceeds the number of sub-samples
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_valid |-> (r_cnt <= HIT_W'(NSAMP)))
        else $error("hit count out of range");

    // no hits gives transparent, and only no hits does
    a_alpha_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_valid && adv4) |=> ((r_alpha == '0) == ($past(r_cnt) == '0)))
        else $error("alpha zero mismatch");

    // full coverage gives opaque
    a_alpha_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_valid && adv4 && (r_cnt == HIT_W'(NSAMP))) |=> (r_alpha == 8'd255))
        else $error("full coverage not opaque");

endmodule

### hw/rtl/supersampled_icon_pixel_shader_core.sv
// Icon pixel shader: takes one pixel coordinate of the 18x18 icon per request and returns
// the configured flat colour with an alpha of floor(255*hits/16), where hits counts the
// 4x4 sub-samples of the pixel that fall inside the selected figure (record circle, stop
// square, play triangle or pause bars). It accepts one pixel every clock while not
// stalled by a held output, and returns one result per pixel, in order.
// The four register stages are the per-axis grid terms, the coverage mask, the hit count
// and the alpha output register; input ready drops only when all four hold an item and the
// output is not taken. Configuration writes are meant to arrive while no pixel is in flight.
module supersampled_icon_pixel_shader_core import sips_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sips_pix_if.sink             i_pix,
    sips_rgba_if.source          o_rgba,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CH_W-1:0]      i_cfg_data
);

    t_shape    r_shape;
    t_color    r_color;
    t_axis_req axis;
    t_mask_req mask;
    logic      cover_ready;
    logic      alpha_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape       <= SHAPE_CIRCLE;
            r_color.red   <= RED_RST;
            r_color.green <= GREEN_RST;
            r_color.blue  <= BLUE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SHAPE: r_shape       <= t_shape'(i_cfg_data[1:0]);
                CFG_RED:   r_color.red   <= i_cfg_data;
                CFG_GREEN: r_color.green <= i_cfg_data;
                CFG_BLUE:  r_color.blue  <= i_cfg_data;
                default:   r_shape       <= r_shape;
            endcase
        end
    end

    // grid terms
    sips_axis u_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_ready (cover_ready),
        .o_axis  (axis)
    );

    // coverage mask
    sips_cover u_cover (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_axis  (axis),
        .i_shape (r_shape),
        .i_ready (alpha_ready),
        .o_ready (cover_ready),
        .o_mask  (mask)
    );

    // hit count and alpha
    sips_alpha u_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mask  (mask),
        .i_color (r_color),
        .o_ready (alpha_ready),
        .o_rgba  (o_rgba)
    );

    // the pipeline backs up only behind a held result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (o_rgba.valid && !o_rgba.ready))
        else $error("input stalled without a held result");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_rgba.valid)
        else $error("result valid right after reset");

    // an empty pipeline takes a pixel at once
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!axis.valid && !mask.valid && !o_rgba.valid) |-> i_pix.ready)
        else $error("empty pipeline not ready");

endmodule
